FILE: design/ffa_pkg.sv
// Shared types, sizing constants and helpers for the first-fit free-list allocator.
package ffa_pkg;

    localparam int HEAP_BYTES   = 1024;
    localparam int ALIGN_BYTES  = 1;
    localparam int HEADER_BYTES = 2;

    // Fixed field widths of the stream beats.
    localparam int REQ_W  = 8;
    localparam int ADDR_W = 10;
    localparam int SIZE_W = 9;

    // Heap offsets carry one extra bit so that HEAP_BYTES itself marks end of list.
    localparam int IDX_W = $clog2(HEAP_BYTES);
    localparam int OFF_W = IDX_W + 1;

    // Width wide enough for any offset, header and size sum.
    localparam int CMP_W = 18;

    localparam logic [0:0] KIND_ALLOC = 1'b0;
    localparam logic [0:0] KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_UNLINK,
        ST_BUMP,
        ST_DONE
    } ffa_state_t;

    // Rounds a request up to the next multiple of ALIGN_BYTES without 8-bit wrap.
    function automatic logic [SIZE_W-1:0] align_up(input logic [REQ_W-1:0] req);
        logic [CMP_W-1:0] sum;
        sum = CMP_W'(req) + CMP_W'(ALIGN_BYTES - 1);
        return SIZE_W'((sum / ALIGN_BYTES) * ALIGN_BYTES);
    endfunction

endpackage

FILE: design/first_fit_free_list_allocator_unit.sv
// Top level of the first-fit free-list allocator with bump fallback.
// A zero-size allocate goes straight to the done state, a free passes the free state, and
// any other allocate walks the free list, reading each link and size through one registered
// memory port and then comparing, before it unlinks a fitting block or bumps or fails.
// Throughput: one item at a time; the next beat is accepted in the cycle after the result
// is loaded, even while it waits. Reset clears bump top, list head and handshake state only.
module first_fit_free_list_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] request_bytes, [17:8] block_address, zero pad
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] granted_address, zero pad
    output logic [1:0]  m_axis_tuser    // [0] failed, [1] reused
);

    localparam logic [ffa_pkg::OFF_W-1:0] END_MARK = ffa_pkg::OFF_W'(ffa_pkg::HEAP_BYTES);

    ffa_pkg::ffa_state_t state_reg, state_next;

    // Allocator state that survives between items.
    logic [ffa_pkg::OFF_W-1:0] head_reg, head_next;
    logic [ffa_pkg::OFF_W-1:0] bump_top_reg, bump_top_next;

    // Latched item and walk registers.
    logic [ffa_pkg::SIZE_W-1:0] need_reg;
    logic [ffa_pkg::ADDR_W-1:0] addr_reg;
    logic [ffa_pkg::OFF_W-1:0]  cur_reg;
    logic [ffa_pkg::OFF_W-1:0]  prev_reg;
    logic [ffa_pkg::OFF_W-1:0]  steps_reg;

    // Result waiting for the output register.
    logic [ffa_pkg::ADDR_W-1:0] res_addr_reg;
    logic                       res_fail_reg;
    logic                       res_reuse_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [ffa_pkg::ADDR_W-1:0] out_addr_reg;
    logic                       out_fail_reg;
    logic                       out_reuse_reg;

    // Memories and their registered read data.
    logic [ffa_pkg::OFF_W-1:0]  link_mem [ffa_pkg::HEAP_BYTES];
    logic [ffa_pkg::SIZE_W-1:0] size_mem [ffa_pkg::HEAP_BYTES];
    logic [ffa_pkg::OFF_W-1:0]  rd_link_reg;
    logic [ffa_pkg::SIZE_W-1:0] rd_size_reg;

    logic                       in_fire;
    logic                       in_kind;
    logic [ffa_pkg::REQ_W-1:0]  in_req;
    logic [ffa_pkg::ADDR_W-1:0] in_addr;

    logic                       walk_go;
    logic                       fit;
    logic                       free_ok;
    logic                       bump_ok;
    logic [ffa_pkg::CMP_W-1:0]  hdr_off;
    logic                       load_out;

    logic                       rd_en;
    logic                       link_we;
    logic [ffa_pkg::IDX_W-1:0]  link_wa;
    logic [ffa_pkg::OFF_W-1:0]  link_wd;
    logic                       size_we;

    assign in_kind = s_axis_tuser;
    assign in_req  = s_axis_tdata[7:0];
    assign in_addr = s_axis_tdata[17:8];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // The walk continues while the link is in the heap and the visit budget remains,
    // which also ends a cyclic list left behind by a double free.
    assign walk_go = (cur_reg < END_MARK) && (steps_reg < END_MARK);

    // The one compare of the walk: stored size against the aligned request.
    assign fit = (rd_size_reg >= need_reg);

    assign hdr_off = ffa_pkg::CMP_W'(addr_reg) - ffa_pkg::CMP_W'(ffa_pkg::HEADER_BYTES);
    assign free_ok = (ffa_pkg::CMP_W'(addr_reg) >= ffa_pkg::CMP_W'(ffa_pkg::HEADER_BYTES))
                  && (hdr_off < ffa_pkg::CMP_W'(ffa_pkg::HEAP_BYTES));

    // A new block fits when header plus aligned size stays inside the heap.
    assign bump_ok = (ffa_pkg::CMP_W'(bump_top_reg) + ffa_pkg::CMP_W'(ffa_pkg::HEADER_BYTES)
                     + ffa_pkg::CMP_W'(need_reg)) <= ffa_pkg::CMP_W'(ffa_pkg::HEAP_BYTES);

    assign load_out = (state_reg == ffa_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_kind == ffa_pkg::KIND_FREE)
                    begin
                        state_next = ffa_pkg::ST_FREE;
                    end
                    else if (in_req == '0)
                    begin
                        state_next = ffa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ffa_pkg::ST_WALK_RD;
                    end
                end
            end
            ffa_pkg::ST_FREE:
            begin
                state_next = ffa_pkg::ST_DONE;
            end
            ffa_pkg::ST_WALK_RD:
            begin
                state_next = walk_go ? ffa_pkg::ST_WALK_CHK : ffa_pkg::ST_BUMP;
            end
            ffa_pkg::ST_WALK_CHK:
            begin
                state_next = fit ? ffa_pkg::ST_UNLINK : ffa_pkg::ST_WALK_RD;
            end
            ffa_pkg::ST_UNLINK:
            begin
                state_next = ffa_pkg::ST_DONE;
            end
            ffa_pkg::ST_BUMP:
            begin
                state_next = ffa_pkg::ST_DONE;
            end
            ffa_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ffa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffa_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: handshake, memory strobes and list state updates.
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        link_we       = 1'b0;
        link_wa       = '0;
        link_wd       = '0;
        size_we       = 1'b0;
        head_next     = head_reg;
        bump_top_next = bump_top_reg;
        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ffa_pkg::ST_FREE:
            begin
                // Push onto the list head; out-of-range addresses are dropped.
                if (free_ok)
                begin
                    link_we   = 1'b1;
                    link_wa   = hdr_off[ffa_pkg::IDX_W-1:0];
                    link_wd   = head_reg;
                    head_next = ffa_pkg::OFF_W'(hdr_off);
                end
            end
            ffa_pkg::ST_WALK_RD:
            begin
                rd_en = walk_go;
            end
            ffa_pkg::ST_UNLINK:
            begin
                if (prev_reg >= END_MARK)
                begin
                    head_next = rd_link_reg;
                end
                else
                begin
                    link_we = 1'b1;
                    link_wa = prev_reg[ffa_pkg::IDX_W-1:0];
                    link_wd = rd_link_reg;
                end
            end
            ffa_pkg::ST_BUMP:
            begin
                if (bump_ok)
                begin
                    link_we       = 1'b1;
                    link_wa       = bump_top_reg[ffa_pkg::IDX_W-1:0];
                    link_wd       = END_MARK;
                    size_we       = 1'b1;
                    bump_top_next = ffa_pkg::OFF_W'(ffa_pkg::CMP_W'(bump_top_reg)
                                    + ffa_pkg::CMP_W'(ffa_pkg::HEADER_BYTES)
                                    + ffa_pkg::CMP_W'(need_reg));
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffa_pkg::ST_IDLE;
            head_reg      <= END_MARK;
            bump_top_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            bump_top_reg <= bump_top_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item, walk and result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            need_reg      <= ffa_pkg::align_up(in_req);
            addr_reg      <= in_addr;
            cur_reg       <= head_reg;
            prev_reg      <= END_MARK;
            steps_reg     <= '0;
            // A zero-size allocate fails at once.
            res_addr_reg  <= '0;
            res_fail_reg  <= 1'b1;
            res_reuse_reg <= 1'b0;
        end
        case (state_reg)
            ffa_pkg::ST_FREE:
            begin
                res_addr_reg  <= '0;
                res_fail_reg  <= 1'b0;
                res_reuse_reg <= 1'b0;
            end
            ffa_pkg::ST_WALK_CHK:
            begin
                if (!fit)
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= rd_link_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
            end
            ffa_pkg::ST_UNLINK:
            begin
                res_addr_reg  <= ffa_pkg::ADDR_W'(ffa_pkg::CMP_W'(cur_reg)
                                 + ffa_pkg::CMP_W'(ffa_pkg::HEADER_BYTES));
                res_fail_reg  <= 1'b0;
                res_reuse_reg <= 1'b1;
            end
            ffa_pkg::ST_BUMP:
            begin
                res_addr_reg  <= bump_ok ? ffa_pkg::ADDR_W'(ffa_pkg::CMP_W'(bump_top_reg)
                                 + ffa_pkg::CMP_W'(ffa_pkg::HEADER_BYTES)) : '0;
                res_fail_reg  <= !bump_ok;
                res_reuse_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_addr_reg  <= res_addr_reg;
            out_fail_reg  <= res_fail_reg;
            out_reuse_reg <= res_reuse_reg;
        end
    end

    // Link and size memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (size_we)
        begin
            size_mem[link_wa] <= need_reg;
        end
        if (rd_en)
        begin
            rd_link_reg <= link_mem[cur_reg[ffa_pkg::IDX_W-1:0]];
            rd_size_reg <= size_mem[cur_reg[ffa_pkg::IDX_W-1:0]];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_addr_reg};
    assign m_axis_tuser  = {out_reuse_reg, out_fail_reg};

`ifndef SYNTHESIS
    a_fail_not_reused: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result marked both failed and reused");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("failed result carries a nonzero address");

    a_bump_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        bump_top_reg <= END_MARK)
        else $error("bump top beyond heap end");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::ST_WALK_CHK) |-> ($past(state_reg) == ffa_pkg::ST_WALK_RD))
        else $error("walk compare without a preceding memory read");

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::ST_WALK_RD) |-> (steps_reg <= END_MARK))
        else $error("free-list walk exceeded its visit budget");
`endif

endmodule

FILE: test/first_fit_free_list_allocator_unit_test.sv
// Self-checking testbench for the first-fit free-list allocator unit.
module first_fit_free_list_allocator_unit_test;

    // A heap walk over a cyclic list visits up to HEAP_BYTES links, each with a memory read
    // and a compare, so the watchdog allows well beyond such a walk before it calls the run hung.
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1800;

    // One expected result beat, field by field.
    typedef struct packed {
        logic [ffa_pkg::ADDR_W-1:0] granted_address;
        logic                       failed;
        logic                       reused;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] request_bytes, [17:8] block_address
    logic        s_axis_tuser = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [9:0] granted_address
    logic [1:0]  m_axis_tuser;        // [0] failed, [1] reused

    // Mirror of the heap bookkeeping, updated as each beat is accepted.
    int                         bump_mark = 0;
    int                         free_head = ffa_pkg::HEAP_BYTES;
    logic [ffa_pkg::OFF_W-1:0]  next_link [ffa_pkg::HEAP_BYTES];
    logic [ffa_pkg::SIZE_W-1:0] block_size [ffa_pkg::HEAP_BYTES];

    grant_t pending_grants[$];
    int     live_blocks[$];   // user addresses currently handed out

    int errors       = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;  // random idling on both sides
    int hold_request = 0;     // receiver hold-off asked for by a test
    int hold_left    = 0;

    first_fit_free_list_allocator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one beat and applies its effect to the mirrored heap.
    // A free pushes the block onto the list head; a nonzero allocate takes the first block on
    // the list that is big enough, and otherwise bumps a new block from the top or fails.
    function automatic grant_t predict_grant(input logic kind,
                                             input logic [ffa_pkg::REQ_W-1:0] req,
                                             input logic [ffa_pkg::ADDR_W-1:0] addr);
        grant_t g;
        int     need;
        int     cur;
        int     prev;
        int     steps;
        g = '0;
        if (kind == ffa_pkg::KIND_FREE)
        begin
            // Address zero and anything inside the first header are ignored.
            if (addr >= ffa_pkg::HEADER_BYTES
                && int'(addr) - ffa_pkg::HEADER_BYTES < ffa_pkg::HEAP_BYTES)
            begin
                next_link[int'(addr) - ffa_pkg::HEADER_BYTES] = ffa_pkg::OFF_W'(free_head);
                free_head = int'(addr) - ffa_pkg::HEADER_BYTES;
            end
            return g;
        end
        if (req == 0)
        begin
            g.failed = 1'b1;
            return g;
        end
        need = ((int'(req) + ffa_pkg::ALIGN_BYTES - 1) / ffa_pkg::ALIGN_BYTES)
               * ffa_pkg::ALIGN_BYTES;
        cur = free_head;
        prev = ffa_pkg::HEAP_BYTES;
        steps = 0;
        // A double free can close the list on itself, so the walk is bounded.
        while (cur < ffa_pkg::HEAP_BYTES && steps < ffa_pkg::HEAP_BYTES)
        begin
            if (int'(block_size[cur]) >= need)
            begin
                if (prev >= ffa_pkg::HEAP_BYTES)
                    free_head = int'(next_link[cur]);
                else
                    next_link[prev] = next_link[cur];
                g.granted_address = ffa_pkg::ADDR_W'(cur + ffa_pkg::HEADER_BYTES);
                g.reused = 1'b1;
                return g;
            end
            prev = cur;
            cur = int'(next_link[cur]);
            steps++;
        end
        if (bump_mark + ffa_pkg::HEADER_BYTES + need > ffa_pkg::HEAP_BYTES)
        begin
            g.failed = 1'b1;
            return g;
        end
        block_size[bump_mark] = ffa_pkg::SIZE_W'(need);
        next_link[bump_mark] = ffa_pkg::OFF_W'(ffa_pkg::HEAP_BYTES);
        g.granted_address = ffa_pkg::ADDR_W'(bump_mark + ffa_pkg::HEADER_BYTES);
        bump_mark += ffa_pkg::HEADER_BYTES + need;
        return g;
    endfunction

    // Offers one beat, holds it until accepted and records the expected result.
    task automatic send_beat(input logic kind, input logic [ffa_pkg::REQ_W-1:0] req,
                             input logic [ffa_pkg::ADDR_W-1:0] addr, output grant_t res);
        if (gaps_on && $urandom_range(99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, addr, req};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
        res = predict_grant(kind, req, addr);
        pending_grants.push_back(res);
    endtask

    // The block address of an allocate beat is unused, so it carries random bits.
    task automatic alloc_beat(input int req, output grant_t res);
        send_beat(ffa_pkg::KIND_ALLOC, ffa_pkg::REQ_W'(req),
                  ffa_pkg::ADDR_W'($urandom_range(0, (1 << ffa_pkg::ADDR_W) - 1)), res);
        if (!res.failed)
            live_blocks.push_back(int'(res.granted_address));
    endtask

    task automatic free_beat(input int addr);
        grant_t res;
        int     hits[$];
        send_beat(ffa_pkg::KIND_FREE, ffa_pkg::REQ_W'($urandom_range(0, 255)),
                  ffa_pkg::ADDR_W'(addr), res);
        hits = live_blocks.find_first_index(item) with (item == addr);
        if (hits.size() != 0)
            live_blocks.delete(hits[0]);
    endtask

    // Lowers tvalid and waits until every expected result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_grants.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // One random beat: mostly allocations of small sizes and frees of live blocks,
    // with a few zero sizes, large sizes and ignored frees mixed in. Ignored frees
    // do not count toward the item total.
    task automatic random_item(output bit counted);
        int     pick;
        int     req;
        int     idx;
        grant_t res;
        pick = $urandom_range(99);
        counted = 1'b1;
        if (live_blocks.size() == 0 || pick < 50)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                req = 0;
            else if (pick < 70)
                req = $urandom_range(1, 16);
            else if (pick < 90)
                req = $urandom_range(17, 64);
            else
                req = $urandom_range(65, 255);
            alloc_beat(req, res);
        end
        else if (pick < 95)
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            free_beat(live_blocks[idx]);
        end
        else
        begin
            free_beat($urandom_range(0, 1));
            counted = 1'b0;
        end
    endtask

    // Zero size, ignored frees, bumping, first-fit reuse in list order, a walk that
    // finds nothing big enough, and a reused block that keeps its larger size.
    task automatic test_directed();
        grant_t res;
        int     a1;
        int     a255;
        int     a3;
        int     a8;
        alloc_beat(0, res);
        free_beat(0);
        free_beat(1);
        alloc_beat(1, res);
        a1 = res.granted_address;
        alloc_beat(255, res);
        a255 = res.granted_address;
        alloc_beat(3, res);
        a3 = res.granted_address;
        alloc_beat(8, res);
        a8 = res.granted_address;
        free_beat(a3);
        free_beat(a8);
        alloc_beat(9, res);
        alloc_beat(2, res);
        alloc_beat(3, res);
        free_beat(a255);
        alloc_beat(100, res);
        free_beat(a1);
        alloc_beat(1, res);
        alloc_beat(255, res);
        drain_results();
    endtask

    // Random traffic, with one long stretch where neither side idles.
    task automatic test_random(input int n_items);
        int count;
        bit counted;
        count = 0;
        while (count < n_items)
        begin
            gaps_on = !(count >= n_items / 3 && count < n_items / 3 + 300);
            random_item(counted);
            if (counted)
                count++;
        end
        gaps_on = 1'b1;
        drain_results();
    endtask

    // Large requests and then tiny ones until the heap refuses.
    task automatic test_exhaust();
        grant_t res;
        int     tries;
        repeat (5) alloc_beat(255, res);
        tries = 0;
        do
        begin
            alloc_beat($urandom_range(1, 4), res);
            tries++;
        end
        while (!res.failed && tries < 400);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering beats,
    // so the output register fills and the block stalls its input.
    task automatic test_backpressure();
        bit counted;
        gaps_on = 1'b0;
        hold_request = 200;
        repeat (12) random_item(counted);
        drain_results();
        gaps_on = 1'b1;
    endtask

    // Short bursts, each followed by a pause until every result is back.
    task automatic test_sender_pause();
        bit counted;
        repeat (3)
        begin
            repeat (5) random_item(counted);
            drain_results();
        end
    endtask

    // Freeing the same block twice points it at itself. A request that is too big for
    // it walks the full bounded loop; one that fits takes it but leaves it at the list head.
    task automatic test_double_free();
        grant_t res;
        int     victim;
        int     hdr;
        if (live_blocks.size() == 0)
            alloc_beat(1, res);
        if (live_blocks.size() != 0)
        begin
            victim = live_blocks[0];
            hdr = victim - ffa_pkg::HEADER_BYTES;
            free_beat(victim);
            free_beat(victim);
            if (block_size[hdr] < 255)
                alloc_beat(255, res);
            alloc_beat(int'(block_size[hdr]), res);
            alloc_beat(int'(block_size[hdr]), res);
        end
        drain_results();
    endtask

    // Receiver: random stalls, plus any hold-off that a test asks for.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(gaps_on && $urandom_range(99) < 10);
    end

    // Each result beat is compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_grants.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, expected nothing got %0d %b %b",
                         $time, m_axis_tdata[ffa_pkg::ADDR_W-1:0], m_axis_tuser[0],
                         m_axis_tuser[1]);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (m_axis_tdata[ffa_pkg::ADDR_W-1:0] !== want.granted_address)
                begin
                    errors++;
                    $display("%0t: granted_address expected %0d got %0d", $time,
                             want.granted_address, m_axis_tdata[ffa_pkg::ADDR_W-1:0]);
                end
                if (m_axis_tuser[0] !== want.failed)
                begin
                    errors++;
                    $display("%0t: failed expected %b got %b", $time, want.failed,
                             m_axis_tuser[0]);
                end
                if (m_axis_tuser[1] !== want.reused)
                begin
                    errors++;
                    $display("%0t: reused expected %b got %b", $time, want.reused,
                             m_axis_tuser[1]);
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(RANDOM_ITEMS);
        test_exhaust();
        test_backpressure();
        test_sender_pause();
        test_double_free();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_grants.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/ffa_pkg.sv
design/first_fit_free_list_allocator_unit.sv
test/first_fit_free_list_allocator_unit_test.sv
